### rtl/core/ndps_pkg.sv
// Shared types and constants for the nibble DFA pattern scanner.
`timescale 1ns / 1ps
`default_nettype none
package ndps_pkg;

  localparam int NODE_W     = 12;
  localparam int NODES      = 4096;
  localparam int NIB_W      = 4;
  localparam int SYM_W      = 8;
  localparam int SYMBOLS    = 256;
  localparam int OFF_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 3;
  localparam int START_W    = 32;
  localparam int RESULT_CAP = 16;
  localparam int INFO_W     = 1 + SYM_W + NODE_W;
  localparam int TRANS_AW   = NODE_W + NIB_W;
  localparam int TRANS_DEPTH = NODES * (1 << NIB_W);
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  // Word kinds carried on in_tuser.
  localparam logic [KIND_W-1:0] KIND_WR_TRANS = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_INFO  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WR_OFF   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DATA     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END      = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] node_addr;
    logic [NIB_W-1:0]  nibble_slot;
    logic [NODE_W-1:0] target_node;
    logic              reports_match;
    logic [SYM_W-1:0]  symbol_id;
    logic [OFF_W-1:0]  offset_value;
    logic [BYTE_W-1:0] data_byte;
  } ndps_cmd_t;

  typedef struct packed {
    logic              is_match;
    logic [SYM_W-1:0]  symbol;
    logic [NODE_W-1:0] next_node;
  } ndps_info_t;

  typedef struct packed {
    logic              rewind;
    logic [NODE_W-1:0] initial_node;
  } ndps_cfg_t;

endpackage
`default_nettype wire

### rtl/core/ndps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ndps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/ndps_front.sv
// Front end: accept input words, drop unused kinds, queue commands for the back end.
`timescale 1ns / 1ps
`default_nettype none
module ndps_front
  import ndps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [KIND_W-1:0]    in_tuser,
  output logic                 q_valid,
  input  logic                 q_ready,
  output ndps_cmd_t            q_cmd
);

  ndps_cmd_t         q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  ndps_cmd_t         in_cmd;
  logic              push;
  logic              pop;

  always_comb begin
    in_cmd.kind          = in_tuser;
    in_cmd.node_addr     = in_tdata[11:0];
    in_cmd.nibble_slot   = in_tdata[15:12];
    in_cmd.target_node   = in_tdata[27:16];
    in_cmd.reports_match = in_tdata[28];
    in_cmd.symbol_id     = in_tdata[36:29];
    in_cmd.offset_value  = in_tdata[44:37];
    in_cmd.data_byte     = in_tdata[52:45];
  end

  assign in_tready = (count_r != QCNT_W'(QDEPTH));
  // Unused kinds are taken and dropped here.
  assign push      = in_tvalid && in_tready && (in_tuser inside {[KIND_WR_TRANS:KIND_END]});
  assign q_valid   = (count_r != '0);
  assign pop       = q_valid && q_ready;
  assign q_cmd     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ndps_back.sv
// Back end: table writes, match chain walk, nibble transitions and result register.
`timescale 1ns / 1ps
`default_nettype none
module ndps_back
  import ndps_pkg::*;
#(
  parameter int MAX_CHAIN = 16,
  parameter int POS_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ndps_cfg_t             cfg,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  ndps_cmd_t             q_cmd,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int HOP_LIMIT = (MAX_CHAIN < RESULT_CAP) ? MAX_CHAIN : RESULT_CAP;
  localparam int HOP_W     = $clog2(HOP_LIMIT + 1);
  localparam logic [HOP_W-1:0] HOP_MAX = HOP_W'(HOP_LIMIT);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_INFO = 3'd2;
  localparam logic [2:0] ST_OFF  = 3'd3;
  localparam logic [2:0] ST_HI   = 3'd4;
  localparam logic [2:0] ST_LO   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  ndps_cmd_t           cmd_r, cmd_nxt;
  logic [NODE_W-1:0]   cur_node_r, cur_node_nxt;
  logic [POS_BITS-1:0] bytes_r, bytes_nxt;
  logic [NODE_W-1:0]   node_r, node_nxt;
  logic [HOP_W-1:0]    hops_r, hops_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [SYM_W-1:0]    pend_sym_r, pend_sym_nxt;
  logic [START_W-1:0]  pend_start_r, pend_start_nxt;
  logic                pend_uf_r, pend_uf_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]    out_sym_r, out_sym_nxt;
  logic [START_W-1:0]  out_start_r, out_start_nxt;
  logic                out_uf_r, out_uf_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic                out_last_r, out_last_nxt;

  // Memory ports
  logic                trans_we, trans_re;
  logic [TRANS_AW-1:0] trans_waddr, trans_raddr;
  logic [NODE_W-1:0]   trans_wdata, trans_rdata;
  logic                info_we, info_re;
  logic [NODE_W-1:0]   info_waddr, info_raddr;
  ndps_info_t          info_wdata, info_rdata;
  logic                off_we, off_re;
  logic [SYM_W-1:0]    off_waddr, off_raddr;
  logic [OFF_W-1:0]    off_wdata, off_rdata;

  logic                out_free;
  logic                chain_cut;
  logic [NODE_W-1:0]   end_node;
  logic [POS_BITS:0]   sub_w;
  logic [POS_BITS+START_W-1:0] start_ext;

  ndps_ram #(.WIDTH(NODE_W), .DEPTH(TRANS_DEPTH)) u_trans_ram (
    .clk(clk), .we(trans_we), .waddr(trans_waddr), .wdata(trans_wdata),
    .re(trans_re), .raddr(trans_raddr), .rdata(trans_rdata)
  );

  ndps_ram #(.WIDTH(INFO_W), .DEPTH(NODES)) u_info_ram (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .re(info_re), .raddr(info_raddr), .rdata(info_rdata)
  );

  ndps_ram #(.WIDTH(OFF_W), .DEPTH(SYMBOLS)) u_off_ram (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .re(off_re), .raddr(off_raddr), .rdata(off_rdata)
  );

  // Borrow out of the subtraction flags a start below zero.
  assign sub_w     = {1'b0, bytes_r} - {{(POS_BITS + 1 - OFF_W){1'b0}}, off_rdata};
  assign start_ext = {{START_W{1'b0}}, sub_w[POS_BITS-1:0]};
  assign out_free  = !out_valid_r || out_tready;
  assign chain_cut = info_rdata.is_match && (hops_r == HOP_MAX);
  assign end_node  = chain_cut ? cfg.initial_node : node_r;
  assign q_ready   = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cur_node_nxt   = cur_node_r;
    bytes_nxt      = bytes_r;
    node_nxt       = node_r;
    hops_nxt       = hops_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_start_nxt = pend_start_r;
    pend_uf_nxt    = pend_uf_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sym_nxt    = out_sym_r;
    out_start_nxt  = out_start_r;
    out_uf_nxt     = out_uf_r;
    out_ovf_nxt    = out_ovf_r;
    out_last_nxt   = out_last_r;
    trans_we       = 1'b0;
    trans_waddr    = {cmd_r.node_addr, cmd_r.nibble_slot};
    trans_wdata    = cmd_r.target_node;
    trans_re       = 1'b0;
    trans_raddr    = {end_node, cmd_r.data_byte[7:4]};
    info_we        = 1'b0;
    info_waddr     = cmd_r.node_addr;
    info_wdata     = '{is_match: cmd_r.reports_match, symbol: cmd_r.symbol_id,
                       next_node: cmd_r.target_node};
    info_re        = 1'b0;
    info_raddr     = cur_node_r;
    off_we         = 1'b0;
    off_waddr      = cmd_r.symbol_id;
    off_wdata      = cmd_r.offset_value;
    off_re         = 1'b0;
    off_raddr      = info_rdata.symbol;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          cmd_nxt   = q_cmd;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        state_nxt = ST_IDLE;
        case (cmd_r.kind)
          KIND_WR_TRANS: trans_we = 1'b1;
          KIND_WR_INFO:  info_we  = 1'b1;
          KIND_WR_OFF:   off_we   = 1'b1;
          KIND_DATA, KIND_END: begin
            info_re        = 1'b1;
            node_nxt       = cur_node_r;
            hops_nxt       = '0;
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_INFO;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_INFO: begin
        // Hold until the previous hop's result can go out.
        if (!(pend_valid_r && !out_free)) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = pend_sym_r;
            out_start_nxt = pend_start_r;
            out_uf_nxt    = pend_uf_r;
            out_ovf_nxt   = chain_cut;
            out_last_nxt  = !info_rdata.is_match || chain_cut;
          end
          pend_valid_nxt = 1'b0;
          if (info_rdata.is_match && !chain_cut) begin
            info_re      = 1'b1;
            info_raddr   = info_rdata.next_node;
            off_re       = 1'b1;
            pend_sym_nxt = info_rdata.symbol;
            node_nxt     = info_rdata.next_node;
            state_nxt    = ST_OFF;
          end else if (cmd_r.kind == KIND_END) begin
            cur_node_nxt = cfg.initial_node;
            bytes_nxt    = '0;
            state_nxt    = ST_IDLE;
          end else begin
            trans_re  = 1'b1;
            state_nxt = ST_HI;
          end
        end
      end
      ST_OFF: begin
        pend_valid_nxt = 1'b1;
        pend_start_nxt = start_ext[START_W-1:0];
        pend_uf_nxt    = sub_w[POS_BITS];
        hops_nxt       = hops_r + 1'b1;
        state_nxt      = ST_INFO;
      end
      ST_HI: begin
        trans_re    = 1'b1;
        trans_raddr = {trans_rdata, cmd_r.data_byte[3:0]};
        state_nxt   = ST_LO;
      end
      ST_LO: begin
        cur_node_nxt = trans_rdata;
        bytes_nxt    = bytes_r + POS_BITS'(1);
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg.rewind) begin
      cur_node_nxt = cfg.initial_node;
      bytes_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_node_r   <= '0;
      bytes_r      <= '0;
      hops_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_node_r   <= cur_node_nxt;
      bytes_r      <= bytes_nxt;
      hops_r       <= hops_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    node_r       <= node_nxt;
    pend_sym_r   <= pend_sym_nxt;
    pend_start_r <= pend_start_nxt;
    pend_uf_r    <= pend_uf_nxt;
    out_sym_r    <= out_sym_nxt;
    out_start_r  <= out_start_nxt;
    out_uf_r     <= out_uf_nxt;
    out_ovf_r    <= out_ovf_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - SYM_W - START_W - 2){1'b0}},
                       out_ovf_r, out_uf_r, out_start_r, out_sym_r};
  assign out_tlast  = out_last_r;

  a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hops_r <= HOP_MAX)
    else $error("chain hop count beyond limit");

  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> state_r == ST_INFO)
    else $error("pending result outside chain walk");

  a_off_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OFF |-> $past(state_r) == ST_INFO)
    else $error("offset fetch without node info");

  a_cut_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> out_last_r)
    else $error("cut chain result not marked last");

endmodule
`default_nettype wire

### rtl/core/nibble_dfa_pattern_scanner_unit.sv
// Top level of the nibble DFA pattern scanner: front end, back end, config port.
`timescale 1ns / 1ps
`default_nettype none
// Runs a loaded automaton over a byte stream, high nibble first. Words of kind
// 0..2 load the transition table (node x 16 slots), per-node match info and
// per-symbol offsets; the tables come up undefined and are never cleared, so
// load every entry a scan can reach. A data word (kind 3) first walks the chain
// of match nodes from the current node, giving one result word per hop (symbol,
// start = bytes consumed minus the symbol's offset, underflow flag), then takes
// two transitions and counts the byte. An end word (kind 4) walks the chain
// and rewinds to initial_node with the count cleared; kinds 5..7 are dropped.
// A chain longer than min(MAX_CHAIN, 16) hops is cut: its last result carries
// the overflow flag and the scan rewinds to initial_node. tlast marks the last
// result of each word. Writing initial_node also rewinds the scan; write it
// only while no word is in flight. The back end takes one word at a time; its
// reads go through the registered single read port of each table (node info
// then offset per hop, two dependent transition reads per byte), and a stalled
// result register holds the chain walk. A four-word queue lets input words
// arrive while the back end works.
module nibble_dfa_pattern_scanner_unit
  import ndps_pkg::*;
#(
  parameter int MAX_CHAIN = 16,
  parameter int POS_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input word stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] node_addr, [15:12] nibble_slot, [27:16] target_node,
  // [28] reports_match, [36:29] symbol_id, [44:37] offset_value,
  // [52:45] data_byte, [55:53] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] kind
  input  logic [KIND_W-1:0]     in_tuser,
  // Result word stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] match_symbol, [39:8] match_start, [40] start_underflow,
  // [41] chain_overflow, [47:42] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  // Configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [1:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [NODE_W-1:0] initial_node_r, initial_node_nxt;
  logic              cfg_wr;
  ndps_cfg_t         cfg;
  logic              q_valid;
  logic              q_ready;
  ndps_cmd_t         q_cmd;

  // Single register; cfg_paddr is not decoded, so every address reaches it.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {{(32 - NODE_W){1'b0}}, initial_node_r};

  assign initial_node_nxt = cfg_wr ? cfg_pwdata[NODE_W-1:0] : initial_node_r;

  // Hand the new value over in the write cycle so the rewind uses it at once.
  assign cfg.rewind       = cfg_wr;
  assign cfg.initial_node = initial_node_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_node_r <= '0;
    end else begin
      initial_node_r <= initial_node_nxt;
    end
  end

  ndps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  ndps_back #(
    .MAX_CHAIN (MAX_CHAIN),
    .POS_BITS  (POS_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
